>>> rtl/ttns_pkg.sv
package ttns_pkg;

   localparam int SCORE_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int VALUE_W    = 20;
   localparam int KEEP_W     = 4;
   localparam int POS_OUT_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int FRAC_LSB   = 12;

   localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 4'd5;
   localparam logic [GAIN_W-1:0] SCORE_GAIN_RESET = 16'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_SCORES     = 2'd3;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               final_score;
   } req_word_type;

   typedef struct packed {
      logic                 valid_res;
      logic [VALUE_W-1:0]   best_value;
      logic [POS_OUT_W-1:0] label_position;
      logic                 last_result;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic insert;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic final_flag;
      logic out_free;
      logic kept_empty;
      logic kept_one;
   } sts_type;

endpackage

>>> rtl/ttns_ctrl.sv
module ttns_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttns_pkg::sts_type sts,
   output ttns_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCALE  = 4'b0010,
      S_INSERT = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_INSERT;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = sts.final_flag ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            // one word per free output slot; stop after the last one
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.kept_empty || sts.kept_one) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/ttns_dp.sv
module ttns_dp #(
   parameter int MAX_KEEP   = 8,
   parameter int MAX_LABELS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ttns_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ttns_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_we,
   input  logic [ttns_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ttns_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  ttns_pkg::cmd_type                   cmd,
   output ttns_pkg::sts_type                   sts
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int POS_W = $clog2(MAX_LABELS);
   localparam int PROD_W = ttns_pkg::SCORE_W + ttns_pkg::GAIN_W;
   localparam int FRAC_SEL_HI = ttns_pkg::FRAC_LSB + ttns_pkg::VALUE_W - 1;

   // configuration
   logic [ttns_pkg::KEEP_W-1:0]  keep_count_ff;
   logic [ttns_pkg::GAIN_W-1:0]  score_gain_ff;
   logic [ttns_pkg::VALUE_W-1:0] score_threshold_ff;
   logic                         byte_scores_ff;

   // item pipeline
   logic [ttns_pkg::SCORE_W-1:0] score_ff;
   logic                         final_ff;
   logic [ttns_pkg::VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]             pos_ff;

   // kept list, descending rank
   logic [ttns_pkg::VALUE_W-1:0]   kval_ff [MAX_KEEP];
   logic [ttns_pkg::POS_OUT_W-1:0] kpos_ff [MAX_KEEP];
   logic [ttns_pkg::VALUE_W-1:0]   kval_in [MAX_KEEP];
   logic [ttns_pkg::POS_OUT_W-1:0] kpos_in [MAX_KEEP];
   logic [CNT_W-1:0]               count_ff, count_in;

   logic                           rsp_valid_ff;
   ttns_pkg::rsp_word_type         rsp_word_ff;

   logic [ttns_pkg::SCORE_W-1:0]   frac;
   logic [PROD_W-1:0]              prod;
   logic [CNT_W-1:0]               limit;
   logic [CNT_W-1:0]               cnt_eff;
   logic [MAX_KEEP-1:0]            greater;
   logic                           slot_ok;
   logic                           ins_en;
   logic [ttns_pkg::POS_OUT_W-1:0] pos_out;

   assign frac = byte_scores_ff ? {score_ff[7:0], score_ff[7:0]} : score_ff;
   assign prod = PROD_W'(frac) * PROD_W'(score_gain_ff);

   assign limit = (32'(keep_count_ff) > 32'(MAX_KEEP)) ? CNT_W'(MAX_KEEP)
                                                       : CNT_W'(keep_count_ff);
   assign cnt_eff = (count_ff > limit) ? limit : count_ff;
   assign pos_out = ttns_pkg::POS_OUT_W'(pos_ff);

   always_comb begin
      greater = '0;
      slot_ok = 1'b0;
      for (int j = 0; j < MAX_KEEP; j++) begin
         greater[j] = (CNT_W'(j) < cnt_eff) && (kval_ff[j] > value_ff);
         if ((CNT_W'(j) < limit) && !greater[j]) slot_ok = 1'b1;
      end
   end

   assign ins_en = cmd.insert && (value_ff >= score_threshold_ff) && slot_ok;

   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         kval_in[j] = kval_ff[j];
         kpos_in[j] = kpos_ff[j];
      end
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = cnt_eff;
         if (ins_en) begin
            // open a gap at the first entry that does not outrank the new one
            if (!greater[0]) begin
               kval_in[0] = value_ff;
               kpos_in[0] = pos_out;
            end
            for (int j = 1; j < MAX_KEEP; j++) begin
               if (!greater[j]) begin
                  if (greater[j-1]) begin
                     kval_in[j] = value_ff;
                     kpos_in[j] = pos_out;
                  end else begin
                     kval_in[j] = kval_ff[j-1];
                     kpos_in[j] = kpos_ff[j-1];
                  end
               end
            end
            count_in = (cnt_eff < limit) ? cnt_eff + CNT_W'(1) : limit;
         end
      end else if (cmd.emit) begin
         // advance the list toward the head
         for (int j = 0; j < MAX_KEEP - 1; j++) begin
            kval_in[j] = kval_ff[j+1];
            kpos_in[j] = kpos_ff[j+1];
         end
         if (count_ff != '0) count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff      <= ttns_pkg::KEEP_COUNT_RESET;
         score_gain_ff      <= ttns_pkg::SCORE_GAIN_RESET;
         score_threshold_ff <= '0;
         byte_scores_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            ttns_pkg::CSR_KEEP_COUNT:
               keep_count_ff <= csr_wdata[ttns_pkg::KEEP_W-1:0];
            ttns_pkg::CSR_SCORE_GAIN:
               score_gain_ff <= csr_wdata[ttns_pkg::GAIN_W-1:0];
            ttns_pkg::CSR_SCORE_THRESHOLD:
               score_threshold_ff <= csr_wdata[ttns_pkg::VALUE_W-1:0];
            ttns_pkg::CSR_BYTE_SCORES:
               byte_scores_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.insert) begin
            if (final_ff || pos_ff == POS_W'(MAX_LABELS - 1)) pos_ff <= '0;
            else pos_ff <= pos_ff + POS_W'(1);
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         score_ff <= req_word.score;
         final_ff <= req_word.final_score;
      end
      if (cmd.scale) value_ff <= prod[FRAC_SEL_HI:ttns_pkg::FRAC_LSB];
      for (int j = 0; j < MAX_KEEP; j++) begin
         kval_ff[j] <= kval_in[j];
         kpos_ff[j] <= kpos_in[j];
      end
      if (cmd.emit) begin
         if (count_ff == '0) begin
            rsp_word_ff <= '{valid_res: 1'b0, best_value: '0, label_position: '0,
                             last_result: 1'b1};
         end else begin
            rsp_word_ff <= '{valid_res: 1'b1, best_value: kval_ff[0],
                             label_position: kpos_ff[0],
                             last_result: (count_ff == CNT_W'(1))};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign sts.final_flag = final_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.kept_empty = (count_ff == '0);
   assign sts.kept_one   = (count_ff == CNT_W'(1));

endmodule

>>> rtl/thresholded_top_n_select.sv
// Thresholded top-N selection. Each accepted req word carries one class score;
// positions count up from 0 per vector. The score is scaled to Q4.16 (byte
// scores are first widened by 257) by the Q4.12 gain, dropped if below the
// threshold, and otherwise inserted into a sorted list of the best keep_count
// entries (at most MAX_KEEP), a newer entry winning ties. On the word marked
// final_score the list drains on rsp, best first, one word per cycle the
// output register is free, with last_result on the final word; an empty list
// gives one word with valid_res low. Each score passes through capture, one
// registered 16x16 multiply and one parallel compare-and-shift insert; a final
// score drains at least one word. req_ready is high only while the controller
// is idle; the output register lets a waiting rsp word hold while the next
// score is taken. Write registers via csr_* only while idle (not enforced).
module thresholded_top_n_select #(
   parameter int MAX_KEEP   = 8,
   parameter int MAX_LABELS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ttns_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ttns_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_we,
   input  logic [ttns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ttns_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ttns_pkg::cmd_type cmd;
   ttns_pkg::sts_type sts;

   // sequence capture, scale, insert and drain
   ttns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // config registers, scaler, kept list and output register
   ttns_dp #(
      .MAX_KEEP   (MAX_KEEP),
      .MAX_LABELS (MAX_LABELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
